// ===== hdl/psob_pkg.sv =====
// ----------------------------------------------------------------------------
// psob_pkg
// Shared types and codes for the price-sorted ask-side order book.
// ----------------------------------------------------------------------------
`default_nettype none
package psob_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_BUY   = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    localparam int unsigned STOCK_W   = 20;
    localparam int unsigned AMOUNT_W  = 36;
    localparam logic [STOCK_W-1:0] STOCK_MAX = '1;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] price;
        logic [15:0] quantity;
        logic        owner_is_group;
        logic [11:0] owner_id;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                fill_owner_is_group;
        logic [11:0]         fill_owner_id;
        logic [15:0]         fill_quantity;
        logic [15:0]         fill_price;
        logic [AMOUNT_W-1:0] amount;
        logic [STOCK_W-1:0]  total_stock;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] price;
        logic [15:0] quantity;
        logic        kind;
        logic [11:0] owner;
    } offer_t;

endpackage
`default_nettype wire

// ===== hdl/psob_front.sv =====
// ----------------------------------------------------------------------------
// psob_front
// Accepts requests, drops undefined operations and queues the rest in a
// two-entry FIFO for the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none
module psob_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  psob_pkg::req_t    s_data,
    output logic              q_valid,
    input  wire               q_ready,
    output psob_pkg::req_t    q_data
);
    import psob_pkg::*;

    req_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    // Undefined operations are taken but never queued.
    assign push    = s_valid && s_ready && (s_data.func != FUNC_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rptr_reg];
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wptr_reg] <= s_data;
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/psob_back.sv =====
// ----------------------------------------------------------------------------
// psob_back
// Execution engine: holds the sorted offer table in registers, inserts in
// parallel, walks offers one at a time for queries and buys, and drives the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
module psob_back #(
    parameter int unsigned OFFER_SLOTS = 16
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               q_valid,
    output logic              q_ready,
    input  psob_pkg::req_t    q_data,
    output logic              m_valid,
    input  wire               m_ready,
    output psob_pkg::rsp_t    m_data
);
    import psob_pkg::*;

    localparam int unsigned IW = (OFFER_SLOTS > 1) ? $clog2(OFFER_SLOTS) : 1;
    localparam int unsigned CW = $clog2(OFFER_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_MUL, S_OUT} state_t;

    offer_t              tab_reg [OFFER_SLOTS];
    logic [CW-1:0]       count_reg;
    logic [STOCK_W-1:0]  stock_reg;
    state_t              state_reg;
    req_t                cur_reg;
    logic [IW-1:0]       idx_reg;
    logic [15:0]         left_reg;
    logic [AMOUNT_W-1:0] cost_reg;
    logic [15:0]         take_reg, tprice_reg;
    logic                tkind_reg;
    logic [11:0]         towner_reg;
    logic                drop_reg, done_reg;
    logic                m_valid_reg;
    rsp_t                m_data_reg;

    logic                out_free;
    logic                emit;
    logic [CW-1:0]       pos;
    logic [STOCK_W:0]    add_sum;
    offer_t              cur_off;
    logic [15:0]         take;
    logic [31:0]         prod;

    function automatic rsp_t plain_rsp(input status_t st, input logic [AMOUNT_W-1:0] amt,
                                       input logic [STOCK_W-1:0] stk);
        rsp_t r;
        r = '0;
        r.status      = st;
        r.amount      = amt;
        r.total_stock = stk;
        r.last        = 1'b1;
        return r;
    endfunction

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE) && out_free;

    // Insertion point: after all offers priced at or below the new one.
    always_comb begin
        pos = CW'(0);
        for (int i = 0; i < OFFER_SLOTS; i++)
            if (CW'(i) < count_reg && tab_reg[i].price <= q_data.price)
                pos = CW'(i + 1);
    end

    // A result is loaded this cycle either straight from an accepted request
    // or from the output state of a walk (each buy fill, or a finished query).
    always_comb begin
        emit = 1'b0;
        if (state_reg == S_IDLE && q_valid && q_ready) begin
            if (q_data.func == FUNC_ADD)
                emit = 1'b1;
            else if ((q_data.func == FUNC_QUERY || q_data.func == FUNC_BUY)
                     && (STOCK_W'(q_data.quantity) > stock_reg
                         || q_data.quantity == 16'd0))
                emit = 1'b1;
        end else if (state_reg == S_OUT && out_free) begin
            emit = 1'b1;
        end
    end

    assign add_sum = {1'b0, stock_reg} + (STOCK_W + 1)'(q_data.quantity);
    // Buys always work at the head; queries walk the index.
    assign cur_off = tab_reg[idx_reg];
    assign take    = (cur_off.quantity < left_reg) ? cur_off.quantity : left_reg;
    assign prod    = take_reg * tprice_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            stock_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= emit || (m_valid_reg && !m_ready);
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        cur_reg    <= q_data;
                        idx_reg    <= '0;
                        left_reg   <= q_data.quantity;
                        cost_reg   <= '0;
                        unique case (func_t'(q_data.func))
                            FUNC_ADD: begin
                                if (q_data.quantity == 16'd0) begin
                                    m_data_reg <= plain_rsp(ST_OK, '0, stock_reg);
                                end else if (count_reg == CW'(OFFER_SLOTS)
                                             || add_sum[STOCK_W]) begin
                                    m_data_reg <= plain_rsp(ST_FULL, '0, stock_reg);
                                end else begin
                                    for (int i = 0; i < OFFER_SLOTS; i++) begin
                                        if (CW'(i) == pos)
                                            tab_reg[i] <= '{q_data.price,
                                                q_data.quantity, q_data.owner_is_group,
                                                q_data.owner_id};
                                        else if (CW'(i) > pos && i > 0)
                                            tab_reg[i] <= tab_reg[i-1];
                                    end
                                    count_reg  <= count_reg + CW'(1);
                                    stock_reg  <= add_sum[STOCK_W-1:0];
                                    m_data_reg <= plain_rsp(ST_OK, '0,
                                                            add_sum[STOCK_W-1:0]);
                                end
                            end
                            FUNC_QUERY, FUNC_BUY: begin
                                if (STOCK_W'(q_data.quantity) > stock_reg) begin
                                    m_data_reg <= plain_rsp(ST_SHORT, '0, stock_reg);
                                end else if (q_data.quantity == 16'd0) begin
                                    m_data_reg <= plain_rsp(ST_OK, '0, stock_reg);
                                end else begin
                                    state_reg <= S_WALK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    // One offer per pass; product formed in the next cycle.
                    take_reg   <= take;
                    tprice_reg <= cur_off.price;
                    tkind_reg  <= cur_off.kind;
                    towner_reg <= cur_off.owner;
                    left_reg   <= left_reg - take;
                    done_reg   <= (left_reg == take);
                    if (cur_reg.func == FUNC_BUY) begin
                        drop_reg <= (cur_off.quantity == take);
                        tab_reg[0].quantity <= cur_off.quantity - take;
                        stock_reg <= stock_reg - STOCK_W'(take);
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (cur_reg.func == FUNC_BUY) begin
                        if (drop_reg) begin
                            for (int i = 0; i + 1 < OFFER_SLOTS; i++)
                                tab_reg[i] <= tab_reg[i+1];
                            count_reg <= count_reg - CW'(1);
                        end
                        state_reg <= S_OUT;
                    end else begin
                        cost_reg <= cost_reg + AMOUNT_W'(prod);
                        state_reg <= done_reg ? S_OUT : S_WALK;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (cur_reg.func == FUNC_BUY) begin
                            m_data_reg <= '{status: ST_OK,
                                            fill_owner_is_group: tkind_reg,
                                            fill_owner_id: towner_reg,
                                            fill_quantity: take_reg,
                                            fill_price: tprice_reg,
                                            amount: AMOUNT_W'(prod),
                                            total_stock: stock_reg,
                                            last: done_reg};
                            state_reg <= done_reg ? S_IDLE : S_WALK;
                        end else begin
                            m_data_reg <= plain_rsp(ST_OK, cost_reg, stock_reg);
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/price_sorted_order_book_top.sv =====
// Add, refused or zero requests reach the output through the queue, then the
// engine and its output register. A query walks each offer through the walk
// and multiply states, then the output state; a buy sends each fill through
// the walk, multiply and output states, and the output can stall the engine.
// One request is executed at a time; two more may wait in the queue.
// Reset (aresetn low, synchronous) empties the book and the queue.
// ----------------------------------------------------------------------------
// price_sorted_order_book_top
// Ask side of a limit order book with a queued front end and serial engine.
// ----------------------------------------------------------------------------
`default_nettype none
module price_sorted_order_book_top #(
    parameter int unsigned OFFER_SLOTS = 16
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  psob_pkg::req_t    s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output psob_pkg::rsp_t    m_data
);
    import psob_pkg::*;

    logic q_valid, q_ready;
    req_t q_data;

    psob_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    psob_back #(.OFFER_SLOTS(OFFER_SLOTS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

// ===== hdl/psob_checker.sv =====
// ----------------------------------------------------------------------------
// psob_checker
// Port-level checks for the order book, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module psob_checker (
    input wire             aclk,
    input wire             aresetn,
    input wire             s_valid,
    input wire             s_ready,
    input psob_pkg::req_t  s_data,
    input wire             m_valid,
    input wire             m_ready,
    input psob_pkg::rsp_t  m_data
);
    import psob_pkg::*;

    // A request is held until taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while stalled");

    // A result is held until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Only ok, full and short are ever reported.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_FULL
                     || m_data.status == ST_SHORT))
        else $error("bad status code");

    // Non-ok results are single and carry no fill.
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.last && m_data.fill_quantity == 16'd0)
        else $error("refused result malformed");

    // Nothing comes out of reset immediately.
    a_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_valid)
        else $error("result after reset");
endmodule

bind price_sorted_order_book_top psob_checker u_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
);
`default_nettype wire
